// ===== hw/rtl/magic_length_frame_deframer_core_assert.svh =====
// Assertion macros for the magic/length frame deframer.
// Used by the top level only; each macro expects clk and rst_n in scope.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mlfd_pkg.sv =====
// Shared types and constants of the magic/length frame deframer.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package mlfd_pkg;

  // Depth of the queues between the three parts of the block.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD       = 2'd0,
    CFG_TIMEOUT_TICKS    = 2'd1,
    CFG_MAX_FRAME_LENGTH = 2'd2
  } cfg_reg_t;

  // Register reset values. The magic word holds 0xC0, 0xC4, 0xFA, 0xCE in
  // order of arrival, first byte in the low eight bits.
  localparam logic [31:0] MAGIC_WORD_RST       = 32'hCEFA_C4C0;
  localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd1000;
  localparam logic [15:0] MAX_FRAME_LENGTH_RST = 16'd2048;

  // Default of the hard cap on the payload length.
  localparam int unsigned MAX_FRAME_DEF = 2048;

  typedef enum logic [2:0] {
    PH_MAGIC0  = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_MAGIC2  = 3'd2,
    PH_MAGIC3  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_LEN_HI  = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_ABORT    = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  // One input word after classification.
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_slot_t;

  // One result word.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } res_slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/magic_length_frame_deframer_core.sv =====
// Magic-word / length-prefixed frame deframer, top level.
// Input words come on a queue-style port: in_push with in_full; a word is taken when
// in_push is high and in_full is low. in_mode 0 carries a received byte in in_rx_byte,
// in_mode 1 is one time tick. Result words leave on out_*: while out_empty is low
// the oldest result is on the ports, and out_pop with out_empty low takes it.
// The block hunts the four magic bytes, reads a little-endian 16-bit length and
// then passes each payload byte on as one result word, with out_last on the final
// one. Empty frames, over-long lengths and inter-byte timeouts after the first payload
// byte give one frame-ending result word each. Configuration (magic word, timeout in
// ticks, length limit) is written through cfg_we/cfg_index/cfg_wdata by the user only
// while the block idles; the block itself does not enforce this. A taken word is stored
// in the input queue, parsed combinationally at its head, and its result registered in
// the result queue. Throughput: one word per cycle while the result queue has room.
// The input queue and the result queue are two words deep each, so the input side
// keeps taking words while up to two results wait. When the receiver stops popping,
// the parser stalls once the result queue is full and in_full rises after two more
// words. Synchronous reset empties both queues, puts the parser back to the hunt
// with the timer disarmed, and restores the register defaults.
`default_nettype none
`include "magic_length_frame_deframer_core_assert.svh"

module magic_length_frame_deframer_core #(
  parameter int unsigned MAX_FRAME = mlfd_pkg::MAX_FRAME_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration port
  input  wire logic                            cfg_we,
  input  wire logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_mode,
  input  wire logic [7:0]                      in_rx_byte,
  // Result channel
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [1:0]                           out_kind,
  output logic [7:0]                           out_data,
  output logic [15:0]                          out_byte_index,
  output logic [15:0]                          out_frame_length,
  output logic                                 out_last
);

  mlfd_pkg::item_slot_t head_item;
  logic                 take;
  mlfd_pkg::res_slot_t  result;
  logic                 res_full;
  mlfd_pkg::res_t       head_res;

  // Front: accepts and classifies input words.
  mlfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .head       (head_item),
    .take       (take)
  );

  // Back: the parser takes one queued word per cycle unless results back up.
  mlfd_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head_item),
    .take      (take),
    .result    (result),
    .res_full  (res_full)
  );

  // Result queue toward the receiver.
  mlfd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .res_full  (res_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .head      (head_res)
  );

  assign out_kind         = head_res.kind;
  assign out_data         = head_res.data;
  assign out_byte_index   = head_res.byte_index;
  assign out_frame_length = head_res.frame_length;
  assign out_last         = head_res.last;

  // The parser must never produce a result the result queue cannot hold.
  `MLFD_ASSERT_NOW(a_no_res_overflow, result.push, !res_full, "result pushed into full queue")

  // Every frame-ending result other than a payload byte closes the frame.
  `MLFD_ASSERT_NOW(a_end_is_last, (!out_empty && out_kind != mlfd_pkg::KIND_PAYLOAD), out_last, "non-payload result without last")

  // A payload byte always lies inside its frame.
  `MLFD_ASSERT_NOW(a_index_in_frame, (!out_empty && out_kind == mlfd_pkg::KIND_PAYLOAD), (out_byte_index < out_frame_length), "payload index beyond frame length")

  // A word that the parser takes from a full input queue frees a place in it.
  `MLFD_ASSERT_NEXT(a_take_frees, (take && !in_push && in_full), !in_full, "taken word did not free the input queue")

endmodule

`default_nettype wire

// ===== hw/rtl/mlfd_front.sv =====
// Front part of the deframer: accepts input words and queues them classified.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_rx_byte,
  output mlfd_pkg::item_slot_t      head,
  input  wire logic                 take
);

  mlfd_pkg::item_t                  mem [mlfd_pkg::QDEPTH];
  logic [mlfd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mlfd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mlfd_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_wr, do_rd;

  assign in_full = (count_r == mlfd_pkg::QCNT_W'(mlfd_pkg::QDEPTH));
  assign do_wr   = in_push && !in_full;
  assign do_rd   = take && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == mlfd_pkg::QPTR_W'(mlfd_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == mlfd_pkg::QPTR_W'(mlfd_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // A tick carries no byte; its byte is stored as zero.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r].is_tick <= in_mode;
      mem[wr_ptr_r].rx_byte <= in_mode ? 8'h00 : in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfd_parser.sv =====
// Back part of the deframer: configuration registers and the frame parser.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_parser #(
  parameter int unsigned MAX_FRAME = mlfd_pkg::MAX_FRAME_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mlfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mlfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  mlfd_pkg::item_slot_t                head,
  output logic                                take,
  output mlfd_pkg::res_slot_t                 result,
  input  wire logic                           res_full
);

  localparam logic [15:0] LIMIT_CAP = 16'(MAX_FRAME);

  logic [31:0]      magic_r;
  logic [15:0]      timeout_r;
  logic [15:0]      max_len_r;

  mlfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      count_r, count_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic             armed_r, armed_nxt;

  logic [15:0]      limit;
  logic [15:0]      timer_inc;
  logic [7:0]       want;
  logic [15:0]      len_full;
  logic [16:0]      idx_inc;
  logic             hunt;
  logic [1:0]       magic_sel;

  assign take      = head.valid && !res_full;
  assign limit     = (LIMIT_CAP < max_len_r) ? LIMIT_CAP : max_len_r;
  assign timer_inc = (timer_r != 16'hFFFF) ? timer_r + 16'd1 : timer_r;
  assign magic_sel = phase_r[1:0];
  assign want      = magic_r[{magic_sel, 3'b000} +: 8];
  assign len_full  = {head.item.rx_byte, len_r[7:0]};
  assign idx_inc   = {1'b0, count_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    timer_nxt = timer_r;
    armed_nxt = armed_r;
    hunt      = 1'b0;

    result.push             = 1'b0;
    result.res.kind         = mlfd_pkg::KIND_PAYLOAD;
    result.res.data         = 8'h00;
    result.res.byte_index   = 16'd0;
    result.res.frame_length = 16'd0;
    result.res.last         = 1'b0;

    if (take) begin
      if (head.item.is_tick) begin
        if (armed_r) begin
          if (timer_inc >= timeout_r) begin
            hunt = 1'b1;
            // An abort is reported only once payload has gone out.
            if (phase_r == mlfd_pkg::PH_PAYLOAD && count_r != 16'd0) begin
              result.push             = 1'b1;
              result.res.kind         = mlfd_pkg::KIND_ABORT;
              result.res.byte_index   = count_r;
              result.res.frame_length = len_r;
              result.res.last         = 1'b1;
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
      end else begin
        timer_nxt = 16'd0;
        armed_nxt = 1'b1;
        case (phase_r)
          mlfd_pkg::PH_MAGIC0, mlfd_pkg::PH_MAGIC1,
          mlfd_pkg::PH_MAGIC2, mlfd_pkg::PH_MAGIC3: begin
            if (head.item.rx_byte == want) begin
              phase_nxt = mlfd_pkg::phase_t'(3'(phase_r) + 3'd1);
            end else begin
              hunt = 1'b1;
            end
          end
          mlfd_pkg::PH_LEN_LO: begin
            len_nxt   = {8'h00, head.item.rx_byte};
            phase_nxt = mlfd_pkg::PH_LEN_HI;
          end
          mlfd_pkg::PH_LEN_HI: begin
            if (len_full == 16'd0) begin
              hunt            = 1'b1;
              result.push     = 1'b1;
              result.res.kind = mlfd_pkg::KIND_EMPTY;
              result.res.last = 1'b1;
            end else if (len_full > limit) begin
              hunt                    = 1'b1;
              result.push             = 1'b1;
              result.res.kind         = mlfd_pkg::KIND_TOO_LONG;
              result.res.frame_length = len_full;
              result.res.last         = 1'b1;
            end else begin
              len_nxt   = len_full;
              count_nxt = 16'd0;
              phase_nxt = mlfd_pkg::PH_PAYLOAD;
            end
          end
          mlfd_pkg::PH_PAYLOAD: begin
            result.push             = 1'b1;
            result.res.kind         = mlfd_pkg::KIND_PAYLOAD;
            result.res.data         = head.item.rx_byte;
            result.res.byte_index   = count_r;
            result.res.frame_length = len_r;
            result.res.last         = (idx_inc >= {1'b0, len_r});
            if (result.res.last) begin
              hunt = 1'b1;
            end else begin
              count_nxt = idx_inc[15:0];
            end
          end
          default: begin
            hunt = 1'b1;
          end
        endcase
      end
    end

    if (hunt) begin
      phase_nxt = mlfd_pkg::PH_MAGIC0;
      len_nxt   = 16'd0;
      count_nxt = 16'd0;
      timer_nxt = 16'd0;
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mlfd_pkg::PH_MAGIC0;
      len_r   <= 16'd0;
      count_r <= 16'd0;
      timer_r <= 16'd0;
      armed_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= mlfd_pkg::MAGIC_WORD_RST;
      timeout_r <= mlfd_pkg::TIMEOUT_TICKS_RST;
      max_len_r <= mlfd_pkg::MAX_FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      case (mlfd_pkg::cfg_reg_t'(cfg_index))
        mlfd_pkg::CFG_MAGIC_WORD:       magic_r   <= cfg_wdata;
        mlfd_pkg::CFG_TIMEOUT_TICKS:    timeout_r <= cfg_wdata[15:0];
        mlfd_pkg::CFG_MAX_FRAME_LENGTH: max_len_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlfd_out_queue.sv =====
// Result queue of the deframer: holds finished words until they are popped.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  mlfd_pkg::res_slot_t result,
  output logic               res_full,
  input  wire logic          out_pop,
  output logic               out_empty,
  output mlfd_pkg::res_t     head
);

  mlfd_pkg::res_t                   mem [mlfd_pkg::QDEPTH];
  logic [mlfd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mlfd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mlfd_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_wr, do_rd;

  assign res_full  = (count_r == mlfd_pkg::QCNT_W'(mlfd_pkg::QDEPTH));
  assign out_empty = (count_r == '0);
  assign do_wr     = result.push && !res_full;
  assign do_rd     = out_pop && !out_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == mlfd_pkg::QPTR_W'(mlfd_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == mlfd_pkg::QPTR_W'(mlfd_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= result.res;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_magic_length_frame_deframer_core.sv =====
// Self-checking testbench for magic_length_frame_deframer_core.
// It drives bytes and ticks, predicts each result word, and checks them in order.
// Depends on mlfd_pkg and the RTL of the deframer only.

module tb_magic_length_frame_deframer_core;
  import mlfd_pkg::*;

  // The hard cap on the payload length is the block's default.
  localparam int unsigned MAX_FRAME = MAX_FRAME_DEF;

  // Words sent in each random phase; six phases give about 2000 words.
  localparam int unsigned WORDS_PER_PHASE = 330;

  // The receiver stops popping for this many cycles once, to fill the block.
  localparam int unsigned RX_HOLD_CYCLES = 400;

  // A taken word is registered in the input queue and its result in the result queue,
  // and up to two more words can sit in the input queue. The settle wait also covers
  // words that give no result.
  localparam int unsigned SETTLE_CYCLES = 8;

  // Bound on waiting for outstanding results before a configuration change.
  localparam int unsigned DRAIN_LIMIT = 20000;

  // This limit lies far above the length of the slowest correct run.
  localparam int unsigned RUN_LIMIT_CYCLES = 400000;

  // Mismatch reports are capped so that a broken block cannot flood the log.
  localparam int unsigned REPORT_CAP = 50;

  // Tracks the parser of the deframer: it mirrors the registers and the parse
  // state, and keeps the result words that are still to come, oldest first.
  class frame_tracker;
    logic [31:0] magic;
    logic [15:0] timeout;
    logic [15:0] max_len;
    phase_t      phase;
    logic [15:0] len_val;
    logic [15:0] count;
    logic [15:0] timer;
    bit          armed;
    res_t        upcoming[$];
    int unsigned mismatches = 0;

    function void go_hunt();
      phase   = PH_MAGIC0;
      len_val = '0;
      count   = '0;
      timer   = '0;
      armed   = 1'b0;
    endfunction

    function void restart();
      magic   = MAGIC_WORD_RST;
      timeout = TIMEOUT_TICKS_RST;
      max_len = MAX_FRAME_LENGTH_RST;
      upcoming.delete();
      go_hunt();
    endfunction

    function void rearm();
      timer = '0;
      armed = 1'b1;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] value);
      case (idx)
        CFG_MAGIC_WORD:       magic   = value;
        CFG_TIMEOUT_TICKS:    timeout = value[15:0];
        CFG_MAX_FRAME_LENGTH: max_len = value[15:0];
        default: ;
      endcase
    endfunction

    function void add_result(kind_t k, logic [7:0] d, logic [15:0] idx,
                             logic [15:0] flen, logic lst);
      res_t r;
      r.kind         = k;
      r.data         = d;
      r.byte_index   = idx;
      r.frame_length = flen;
      r.last         = lst;
      upcoming.push_back(r);
    endfunction

    // Advances the parse state by one accepted word and queues its result.
    function void note_word(logic is_tick, logic [7:0] b);
      logic [15:0] passed;
      logic [15:0] flen;
      logic [15:0] len;
      logic [15:0] limit;
      logic [16:0] next_idx;
      logic [7:0]  want_byte;
      bit          report;
      if (is_tick) begin
        // Ticks only count while a frame is under way.
        if (!armed) return;
        if (timer != 16'hFFFF) timer = timer + 16'd1;
        if (timer >= timeout) begin
          // An abort is only reported when payload has already gone out.
          report = (phase == PH_PAYLOAD) && (count != 16'd0);
          passed = count;
          flen   = len_val;
          go_hunt();
          if (report) add_result(KIND_ABORT, 8'd0, passed, flen, 1'b1);
        end
        return;
      end
      case (phase)
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
          want_byte = 8'(magic >> (8 * int'(phase)));
          if (b == want_byte) begin
            phase = phase_t'(phase + 1);
            rearm();
          end else begin
            // The byte that broke the match is not tried as a first byte.
            go_hunt();
          end
        end
        PH_LEN_LO: begin
          len_val = {8'd0, b};
          phase   = PH_LEN_HI;
          rearm();
        end
        PH_LEN_HI: begin
          len   = {b, len_val[7:0]};
          limit = (max_len < MAX_FRAME) ? max_len : 16'(MAX_FRAME);
          if (len == 16'd0) begin
            go_hunt();
            add_result(KIND_EMPTY, 8'd0, 16'd0, 16'd0, 1'b1);
          end else if (len > limit) begin
            go_hunt();
            add_result(KIND_TOO_LONG, 8'd0, 16'd0, len, 1'b1);
          end else begin
            len_val = len;
            count   = 16'd0;
            phase   = PH_PAYLOAD;
            rearm();
          end
        end
        PH_PAYLOAD: begin
          next_idx = {1'b0, count} + 17'd1;
          flen     = len_val;
          if (next_idx >= {1'b0, flen}) begin
            add_result(KIND_PAYLOAD, b, count, flen, 1'b1);
            go_hunt();
          end else begin
            add_result(KIND_PAYLOAD, b, count, flen, 1'b0);
            count = next_idx[15:0];
            rearm();
          end
        end
        default: go_hunt();
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Checks one popped result word against the oldest one still to come.
    function void check_word(res_t got);
      res_t want;
      if (upcoming.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result word popped while none was due (kind %0d)", got.kind);
        return;
      end
      want = upcoming.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data", want.data, got.data);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic                  in_mode;
  logic [7:0]            in_rx_byte;
  logic                  out_empty;
  logic                  out_pop;
  logic [1:0]            out_kind;
  logic [7:0]            out_data;
  logic [15:0]           out_byte_index;
  logic [15:0]           out_frame_length;
  logic                  out_last;

  frame_tracker tracker = new;
  res_t         seen_word;

  // Idle rates in percent for both sides, changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;

  // A request from the stimulus for one long receiver stall, and its countdown.
  bit          rx_hold_req;
  int unsigned rx_hold_left;

  magic_length_frame_deframer_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_last        (out_last)
  );

  always #10 clk = ~clk;

  // Receiver. It decides at each falling edge whether to pop in the next cycle.
  // When a stall is requested it keeps pop low for a long stretch so that the
  // result queue fills and the block pushes back on its input.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // A result word is taken at a rising edge with pop high and empty low. The
  // values read here are the ones that stood before the edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_pop && !out_empty) begin
      seen_word.kind         = kind_t'(out_kind);
      seen_word.data         = out_data;
      seen_word.byte_index   = out_byte_index;
      seen_word.frame_length = out_frame_length;
      seen_word.last         = out_last;
      tracker.check_word(seen_word);
    end
  end

  // Offers one word, with random idle cycles first, and holds it until the
  // block takes it. Called and left at a falling edge; push stays high on
  // return so that back-to-back words need no gap.
  task automatic push_word(logic is_tick, logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push    <= 1'b1;
    in_mode    <= is_tick;
    in_rx_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_full;
      if (!taken) @(negedge clk);
    end
    tracker.note_word(is_tick, b);
    words_sent++;
    @(negedge clk);
  endtask

  // Sometimes sends a run of ticks. With a short timeout the run may be long
  // enough to expire the timer; with a long one it only exercises counting.
  task automatic tick_burst();
    int unsigned top;
    int unsigned n;
    if ($urandom_range(99) < 10) begin
      top = (tracker.timeout <= 16) ? tracker.timeout + 1 : 3;
      n   = $urandom_range(top, 1);
      repeat (n) push_word(1'b1, 8'($urandom_range(255)));
    end
  endtask

  task automatic put_byte(logic [7:0] b, bit noisy);
    if (noisy) tick_burst();
    push_word(1'b0, b);
  endtask

  // The four magic bytes as currently configured, then the length, low byte first.
  task automatic send_header(logic [15:0] len, bit noisy);
    for (int k = 0; k < 4; k++) put_byte(tracker.magic[8*k +: 8], noisy);
    put_byte(len[7:0], noisy);
    put_byte(len[15:8], noisy);
  endtask

  // One random stretch of stimulus: mostly a frame with random length (at times empty or
  // too long) and random content, otherwise a magic word cut short or plain line noise.
  task automatic send_frame();
    int unsigned shape;
    int unsigned r;
    int unsigned limit;
    int unsigned len;
    int unsigned n;
    limit = (tracker.max_len < MAX_FRAME) ? tracker.max_len : MAX_FRAME;
    shape = $urandom_range(99);
    if (shape < 75) begin
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 12) len = limit + 1;
      else if (r < 14) len = 16'hFFFF;
      else if (r < 18) len = $urandom_range(65535, limit + 1);
      else if (r < 24 && limit <= 64) len = limit;
      else len = $urandom_range((limit < 12) ? limit : 12, 1);
      send_header(16'(len), 1'b1);
      if (len >= 1 && len <= limit)
        repeat (len) put_byte(8'($urandom_range(255)), 1'b1);
    end else if (shape < 88) begin
      n = $urandom_range(3, 1);
      for (int k = 0; k < n; k++) put_byte(tracker.magic[8*k +: 8], 1'b1);
      put_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) put_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Stops sending and waits until every due result has been popped, then waits on
  // for words that are still in flight but give no result.
  task automatic settle();
    int unsigned waited;
    in_push <= 1'b0;
    waited = 0;
    while (tracker.upcoming.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers on consecutive edges. Only called while idle.
  task automatic write_regs(logic [31:0] magic, logic [15:0] ticks, logic [15:0] max_len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC_WORD;
    cfg_wdata <= magic;
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= {16'd0, ticks};
    @(negedge clk);
    cfg_index <= CFG_MAX_FRAME_LENGTH;
    cfg_wdata <= {16'd0, max_len};
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(CFG_MAGIC_WORD, magic);
    tracker.write_reg(CFG_TIMEOUT_TICKS, {16'd0, ticks});
    tracker.write_reg(CFG_MAX_FRAME_LENGTH, {16'd0, max_len});
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MAGIC_WORD;
    cfg_wdata     = '0;
    in_push       = 1'b0;
    in_mode       = 1'b0;
    in_rx_byte    = 8'd0;
    out_pop       = 1'b0;
    rx_hold_req   = 1'b0;
    rx_hold_left  = 0;
    words_sent    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 54;
    tracker.restart();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words on the reset configuration. A tick while hunting is
    // ignored, a zero length gives an empty frame, and a repeated first magic
    // byte breaks the match without starting a new one.
    push_word(1'b1, 8'hFF);
    send_header(16'd0, 1'b0);
    push_word(1'b0, tracker.magic[7:0]);
    push_word(1'b0, tracker.magic[7:0]);
    // One above the hard cap is rejected as too long.
    send_header(16'(MAX_FRAME + 1), 1'b0);
    // A two-byte frame with the extreme byte values.
    send_header(16'd2, 1'b0);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'hFF);
    settle();

    // The receiver stalls for a long stretch while a 40-byte frame is offered,
    // so the block fills up and holds in_full high until popping resumes. The
    // sender then waits until every result has come out.
    rx_hold_req = 1'b1;
    send_header(16'd40, 1'b0);
    repeat (40) push_word(1'b0, 8'($urandom_range(255)));
    settle();

    // Random phases, each on its own register setting. The first two phases
    // idle sender and receiver at one ratio, the next two at the reverse, and
    // the last two do not idle at all.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs($urandom, 16'd6, 16'd16);
        1: write_regs(32'h0000_0000, 16'd1, 16'hFFFF);
        2: write_regs(32'hFFFF_FFFF, 16'hFFFF, 16'd1);
        3: write_regs($urandom, 16'($urandom_range(10, 2)), 16'(MAX_FRAME + 1));
        4: write_regs(MAGIC_WORD_RST, 16'd3, 16'(MAX_FRAME));
        default: write_regs($urandom, 16'($urandom_range(65535, 1)),
                            16'($urandom_range(65535, 1)));
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) send_frame();
      settle();
    end

    if (tracker.upcoming.size() != 0) begin
      $error("%0d result words never arrived", tracker.upcoming.size());
      tracker.mismatches += tracker.upcoming.size();
    end
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guards against a hang, such as in_full stuck high or a result never showing.
  initial begin
    #(RUN_LIMIT_CYCLES * 20);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
